>>> hdl/fepp_pkg.sv
package fepp_pkg;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int CV_W       = 16;
	localparam int DT_W       = 16;
	localparam int FB_W       = 16;
	// feedback_gain * 8 + feedback_cv, Q.15
	localparam int GAIN_W     = 20;
	// 2 * delay_time + delay_cv
	localparam int DSUM_W     = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_TIME    = 2'd0,
		REG_FEEDBACK_GAIN = 2'd1,
		REG_BOUNCE_MODE   = 2'd2
	} cfg_idx_t;

	// Register reset values: 0.75 of the buffer, gain 0.4
	localparam logic [DT_W-1:0] DELAY_TIME_RST    = 16'd24576;
	localparam logic [FB_W-1:0] FEEDBACK_GAIN_RST = 16'd1638;

	typedef struct packed {
		logic [DT_W-1:0] delay_time;
		logic [FB_W-1:0] feedback_gain;
		logic            bounce_mode;
	} cfg_t;

endpackage

>>> hdl/fepp_ifs.sv
interface fepp_in_if;
	import fepp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] audio_in;
	logic signed [CV_W-1:0]     delay_cv;
	logic signed [CV_W-1:0]     feedback_cv;

	modport source (output valid, audio_in, delay_cv, feedback_cv, input ready);
	modport sink (input valid, audio_in, delay_cv, feedback_cv, output ready);
endinterface

interface fepp_out_if;
	import fepp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

>>> hdl/fepp_fifo.sv
module fepp_fifo #(
	parameter int W = 52
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	import fepp_pkg::*;

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= in_data;
	end

endmodule

>>> hdl/fepp_front.sv
module fepp_front #(
	parameter int MAX_DELAY_SAMPLES = 65536,
	localparam int LW = $clog2(MAX_DELAY_SAMPLES),
	localparam int QW = fepp_pkg::SAMPLE_W + fepp_pkg::GAIN_W + LW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fepp_pkg::cfg_t cfg,
	input  logic           clearing,
	fepp_in_if.sink        din,
	output logic           q_valid,
	input  logic           q_ready,
	output logic [QW-1:0]  q_data
);
	import fepp_pkg::*;

	localparam int PW = DSUM_W + $clog2(MAX_DELAY_SAMPLES + 1) + 1;
	localparam logic signed [PW-1:0] SIZE_S  = PW'(MAX_DELAY_SAMPLES);
	localparam logic signed [PW-1:0] LEN_MAX = PW'(MAX_DELAY_SAMPLES - 1);
	localparam logic signed [PW-1:0] ONE_S   = PW'(1);

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [DSUM_W-1:0]   dsum_s1;
	logic signed [GAIN_W-1:0]   gain_s1;
	logic signed [DSUM_W-1:0]   dsum;
	logic signed [GAIN_W-1:0]   gain;
	logic signed [PW-1:0]       prod;
	logic signed [PW-1:0]       lenm1;
	logic [LW-1:0]              len;
	logic                       take;

	// Delay sum and effective gain from the incoming transaction
	assign dsum = $signed({2'b00, cfg.delay_time, 1'b0}) + DSUM_W'(din.delay_cv);
	assign gain = $signed({cfg.feedback_gain[FB_W-1], cfg.feedback_gain, 3'b000})
		+ GAIN_W'(din.feedback_cv);

	assign din.ready = !clearing && (!valid_s1 || q_ready);
	assign take      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= din.audio_in;
			dsum_s1   <= dsum;
			gain_s1   <= gain;
		end
	end

	// Delay length: floor(dsum * size / 65536) - 1, clamped to the buffer
	assign prod  = PW'(dsum_s1) * SIZE_S;
	assign lenm1 = (prod >>> 16) - ONE_S;

	always_comb begin
		if (lenm1 < 0)
			len = '0;
		else if (lenm1 > LEN_MAX)
			len = LW'(MAX_DELAY_SAMPLES - 1);
		else
			len = lenm1[LW-1:0];
	end

	assign q_valid = valid_s1;
	assign q_data  = {sample_s1, gain_s1, len};

endmodule

>>> hdl/fepp_back.sv
module fepp_back #(
	parameter int MAX_DELAY_SAMPLES = 65536,
	localparam int LW = $clog2(MAX_DELAY_SAMPLES),
	localparam int QW = fepp_pkg::SAMPLE_W + fepp_pkg::GAIN_W + LW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fepp_pkg::cfg_t cfg,
	output logic           clearing,
	input  logic           q_valid,
	output logic           q_ready,
	input  logic [QW-1:0]  q_data,
	fepp_out_if.source     dout
);
	import fepp_pkg::*;

	localparam int HW     = $clog2(MAX_DELAY_SAMPLES + 1);
	localparam int PROD_W = SAMPLE_W + GAIN_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_READ  = 3'b010,
		ST_WRITE = 3'b100
	} back_state_t;

	back_state_t                state_q;
	logic [LW-1:0]              clr_q;
	logic [HW-1:0]              head_q;
	logic                       pri_b_q;
	logic [LW-1:0]              len_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [GAIN_W-1:0]   gain_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	logic [SAMPLE_W-1:0]        mem_a [MAX_DELAY_SAMPLES];
	logic [SAMPLE_W-1:0]        mem_b [MAX_DELAY_SAMPLES];
	logic signed [SAMPLE_W-1:0] rd_a_q;
	logic signed [SAMPLE_W-1:0] rd_b_q;

	logic signed [SAMPLE_W-1:0] q_sample;
	logic signed [GAIN_W-1:0]   q_gain;
	logic [LW-1:0]              q_len;
	logic [HW-1:0]              head_wrap;
	logic                       pri_next;
	logic                       issue;
	logic                       out_free;
	logic                       commit;
	logic signed [SAMPLE_W-1:0] old_pri;
	logic signed [SAMPLE_W-1:0] old_sec;
	logic signed [PROD_W-1:0]   prod;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    shifted;
	logic signed [SAMPLE_W-1:0] new_val;
	logic [LW-1:0]              waddr;
	logic                       we_a;
	logic                       we_b;
	logic [SAMPLE_W-1:0]        wd_a;
	logic [SAMPLE_W-1:0]        wd_b;

	// Queue entry fields
	assign q_sample = $signed(q_data[QW-1 -: SAMPLE_W]);
	assign q_gain   = $signed(q_data[LW +: GAIN_W]);
	assign q_len    = q_data[LW-1:0];

	// Head wrap and ping-pong swap at head zero
	assign head_wrap = (head_q > HW'(q_len)) ? '0 : head_q;
	assign pri_next  = pri_b_q ^ (cfg.bounce_mode && (head_wrap == '0));

	assign clearing = (state_q == ST_CLEAR);
	assign q_ready  = (state_q == ST_READ);
	assign issue    = q_ready && q_valid;
	assign out_free = !out_valid_q || dout.ready;
	assign commit   = (state_q == ST_WRITE) && out_free;

	// Feedback multiply-accumulate, round half up, saturate
	assign old_pri = pri_b_q ? rd_b_q : rd_a_q;
	assign old_sec = pri_b_q ? rd_a_q : rd_b_q;
	assign prod    = PROD_W'(old_pri) * PROD_W'(gain_q);
	assign acc     = (ACC_W'(sample_q) <<< 15) + ACC_W'(prod) + RND_HALF;
	assign shifted = acc >>> 15;

	always_comb begin
		if (shifted > SAT_MAX)
			new_val = 16'sh7fff;
		else if (shifted < SAT_MIN)
			new_val = -16'sh8000;
		else
			new_val = shifted[SAMPLE_W-1:0];
	end

	// Memory write side: clearing pass, or primary update plus secondary clear with bounce mode off
	assign waddr = clearing ? clr_q : head_q[LW-1:0];
	assign we_a  = clearing || (commit && (!pri_b_q || !cfg.bounce_mode));
	assign we_b  = clearing || (commit && (pri_b_q || !cfg.bounce_mode));
	assign wd_a  = (commit && !pri_b_q) ? new_val : '0;
	assign wd_b  = (commit && pri_b_q) ? new_val : '0;

	always_ff @(posedge clk) begin
		if (we_a)
			mem_a[waddr] <= wd_a;
		if (issue)
			rd_a_q <= $signed(mem_a[head_wrap[LW-1:0]]);
	end

	always_ff @(posedge clk) begin
		if (we_b)
			mem_b[waddr] <= wd_b;
		if (issue)
			rd_b_q <= $signed(mem_b[head_wrap[LW-1:0]]);
	end

	// Control sequence: clear, then read / write per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			pri_b_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(MAX_DELAY_SAMPLES - 1))
						state_q <= ST_READ;
				end
				ST_READ: begin
					if (q_valid) begin
						head_q  <= head_wrap;
						pri_b_q <= pri_next;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						head_q  <= head_q + HW'(1);
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Per-transaction operands
	always_ff @(posedge clk) begin
		if (issue) begin
			len_q    <= q_len;
			sample_q <= q_sample;
			gain_q   <= q_gain;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			left_q  <= new_val;
			right_q <= cfg.bounce_mode ? old_sec : '0;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.left_out  = left_q;
	assign dout.right_out = right_q;

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_ready)
		else $error("queue popped during clearing pass");

	a_head_in_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (head_q <= HW'(len_q)))
		else $error("head beyond delay length");

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> ($past(clr_q) == LW'(MAX_DELAY_SAMPLES - 1)))
		else $error("clearing pass ended early");

	a_pop_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> (state_q == ST_WRITE))
		else $error("popped transaction not carried to write");

endmodule

>>> hdl/feedback_echo_ping_pong.sv
// Ping-pong feedback echo, one sample per transaction.
// Path to a valid result: front stage register, queue, head read, output register.
// The back end takes one transaction at a time: a read then a write of the
// head entry in the delay memories; the front stage and queue take input meanwhile.
// Reset: loads the configuration reset values and clears the control state, then
// a clearing pass zeroes both delay memories; no input is accepted until it ends.
module feedback_echo_ping_pong #(
	parameter int MAX_DELAY_SAMPLES = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fepp_in_if.sink                         din,
	fepp_out_if.source                      dout,
	input  logic                            cfg_we,
	input  logic [fepp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fepp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fepp_pkg::*;

	localparam int LW = $clog2(MAX_DELAY_SAMPLES);
	localparam int QW = SAMPLE_W + GAIN_W + LW;

	cfg_t          cfg_q;
	logic          clearing;
	logic          fq_in_valid;
	logic          fq_in_ready;
	logic [QW-1:0] fq_in_data;
	logic          fq_out_valid;
	logic          fq_out_ready;
	logic [QW-1:0] fq_out_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_time    <= DELAY_TIME_RST;
			cfg_q.feedback_gain <= FEEDBACK_GAIN_RST;
			cfg_q.bounce_mode   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_DELAY_TIME:    cfg_q.delay_time    <= cfg_wdata[DT_W-1:0];
				REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_wdata[FB_W-1:0];
				REG_BOUNCE_MODE:   cfg_q.bounce_mode   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	fepp_front #(
		.MAX_DELAY_SAMPLES(MAX_DELAY_SAMPLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.din      (din),
		.q_valid  (fq_in_valid),
		.q_ready  (fq_in_ready),
		.q_data   (fq_in_data)
	);

	fepp_fifo #(
		.W(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_in_valid),
		.in_ready  (fq_in_ready),
		.in_data   (fq_in_data),
		.out_valid (fq_out_valid),
		.out_ready (fq_out_ready),
		.out_data  (fq_out_data)
	);

	fepp_back #(
		.MAX_DELAY_SAMPLES(MAX_DELAY_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.q_valid  (fq_out_valid),
		.q_ready  (fq_out_ready),
		.q_data   (fq_out_data),
		.dout     (dout)
	);

endmodule

>>> tb/tb_feedback_echo_ping_pong.sv
module tb_feedback_echo_ping_pong;
	import fepp_pkg::*;

	localparam int STORE_DEPTH   = 65536;
	localparam int HEAD_W        = $clog2(STORE_DEPTH);
	// after the last result, give the pipeline slack before touching registers
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_CAP    = 40;
	// index past the register list, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} echo_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fepp_in_if  din_if ();
	fepp_out_if dout_if ();

	feedback_echo_ping_pong #(
		.MAX_DELAY_SAMPLES(STORE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din_if),
		.dout     (dout_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Echo state mirror
	shortint                echo_a [STORE_DEPTH];
	shortint                echo_b [STORE_DEPTH];
	int unsigned            head;
	bit                     primary_b;
	logic [DT_W-1:0]        model_delay;
	logic signed [FB_W-1:0] model_gain;
	bit                     model_bounce;

	echo_out_t   pending_echoes[$];
	echo_out_t   oldest_echo;
	int unsigned mismatch_count;
	int unsigned samples_sent;
	int unsigned echoes_checked;
	int unsigned wrap_count;
	int unsigned swap_count;
	int unsigned sat_count;
	int unsigned settings_count;

	// Sender pacing
	int unsigned burst_left;
	bit          offering;
	bit          allow_gaps;

	// Receiver hold-off request, picked up by the receiver process
	int unsigned hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compute the expected left/right pair for one accepted sample
	function automatic void predict_echo(input logic signed [SAMPLE_W-1:0] smp,
			input logic signed [CV_W-1:0] dcv, input logic signed [CV_W-1:0] fcv);
		longint            span;
		longint            loop_len;
		longint            gain;
		longint            acc;
		longint            mixed;
		shortint           prev;
		shortint           fresh;
		echo_out_t         res;
		logic [HEAD_W-1:0] slot;

		// loop length as a fraction of the store
		span = 2 * longint'(model_delay) + longint'(dcv);
		if (span <= 0) begin
			loop_len = 0;
		end else begin
			loop_len = span * STORE_DEPTH / 65536 - 1;
			if (loop_len < 0)
				loop_len = 0;
			if (loop_len > STORE_DEPTH - 1)
				loop_len = STORE_DEPTH - 1;
		end

		if (longint'(head) > loop_len || head >= STORE_DEPTH) begin
			head = 0;
			wrap_count++;
		end
		if (model_bounce && head == 0) begin
			primary_b = !primary_b;
			swap_count++;
		end
		slot = HEAD_W'(head);

		// input + old * gain, Q.30, round half up, saturate
		prev  = primary_b ? echo_b[slot] : echo_a[slot];
		gain  = longint'(model_gain) * 8 + longint'(fcv);
		acc   = longint'(smp) * 32768 + longint'(prev) * gain;
		mixed = (acc + 16384) >>> 15;
		if (mixed > 32767) begin
			fresh = 16'sh7FFF;
			sat_count++;
		end else if (mixed < -32768) begin
			fresh = -16'sh8000;
			sat_count++;
		end else begin
			fresh = shortint'(mixed);
		end

		if (primary_b)
			echo_b[slot] = fresh;
		else
			echo_a[slot] = fresh;
		if (!model_bounce) begin
			if (primary_b)
				echo_a[slot] = 0;
			else
				echo_b[slot] = 0;
		end

		res.left_out  = fresh;
		res.right_out = primary_b ? echo_a[slot] : echo_b[slot];
		pending_echoes.insert(pending_echoes.size(), res);
		head++;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("[%0t] echo check: %s", $time, what);
	endtask

	// Offer one sample and wait for the transaction; gaps between bursts if allowed
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
			input logic signed [CV_W-1:0] dcv, input logic signed [CV_W-1:0] fcv);
		din_if.valid       <= 1'b1;
		din_if.audio_in    <= smp;
		din_if.delay_cv    <= dcv;
		din_if.feedback_cv <= fcv;
		offering = 1'b1;
		do begin
			@(posedge clk);
		end while (!din_if.ready);
		predict_echo(smp, dcv, fcv);
		samples_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (allow_gaps) begin
				din_if.valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_sample();
		logic signed [SAMPLE_W-1:0] smp;
		logic signed [CV_W-1:0]     dcv;
		logic signed [CV_W-1:0]     fcv;

		if ($urandom_range(0, 9) == 0)
			smp = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
		else
			smp = 16'($urandom);
		// short loops make the head come back to fresh entries
		if (model_delay <= 40 && $urandom_range(0, 6) != 0)
			dcv = 16'(int'($urandom_range(0, 70)) - 10);
		else
			dcv = 16'($urandom);
		if ($urandom_range(0, 1) != 0)
			fcv = 16'(int'($urandom_range(0, 2000)) - 1000);
		else
			fcv = 16'($urandom);
		send_sample(smp, dcv, fcv);
	endtask

	// Stop offering, wait for every echo, let the pipeline settle
	task automatic drain_echoes();
		if (offering) begin
			din_if.valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_echoes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; end_reg_writes lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_DELAY_TIME:    model_delay  = val;
			REG_FEEDBACK_GAIN: model_gain   = val;
			REG_BOUNCE_MODE:   model_bounce = val[0];
			default: ;
		endcase
	endtask

	task automatic end_reg_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [DT_W-1:0] dt, input logic [FB_W-1:0] fg,
			input bit bm);
		drain_echoes();
		write_reg(REG_DELAY_TIME, dt);
		write_reg(REG_FEEDBACK_GAIN, fg);
		// upper bits of the bounce write carry junk
		write_reg(REG_BOUNCE_MODE, {15'($urandom), bm});
		if ($urandom_range(0, 1) != 0)
			write_reg(REG_UNUSED, 16'($urandom));
		end_reg_writes();
		settings_count++;
	endtask

	// Reset values, field extremes, long loop
	task automatic test_reset_defaults();
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sh7FFF, 16'sd0, 16'sd0);
		send_sample(-16'sh8000, 16'sd0, 16'sd0);
		send_sample(16'sd1234, 16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sd1234, -16'sh8000, -16'sh8000);
		send_sample(16'sh7FFF, -16'sh8000, 16'sh7FFF);
	endtask

	// Two-entry and one-entry loops with maximal gain, both saturation ends
	task automatic test_short_loop_saturation();
		configure(16'd0, 16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 16'sd2, 16'sd0);
		send_sample(-16'sh8000, 16'sd2, 16'sd0);
		send_sample(16'sd16384, 16'sd2, 16'sh7FFF);
		send_sample(16'sd100, 16'sd2, -16'sh8000);
		// zero and negative delay sums, and a sum of exactly one entry
		send_sample(16'sd5, 16'sd0, 16'sd0);
		send_sample(-16'sd5, -16'sh8000, 16'sd0);
		send_sample(16'sd7, 16'sd1, 16'sd0);
		configure(16'd0, -16'sh8000, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sh7FFF);
	endtask

	// Ping-pong swapping on every wrap, then back to clearing the second store
	task automatic test_bounce_swap();
		configure(16'd1, 16'sd4096, 1'b1);
		send_sample(16'sd1000, 16'sd0, 16'sd0);
		send_sample(16'sd2000, 16'sd0, 16'sd0);
		send_sample(16'sd3000, 16'sd0, 16'sd0);
		send_sample(16'sd4000, 16'sd0, 16'sd0);
		send_sample(-16'sh8000, 16'sd0, 16'sh7FFF);
		send_sample(16'sh7FFF, 16'sd0, -16'sh8000);
		configure(16'd1, 16'sd4096, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
	endtask

	task automatic test_extreme_registers();
		configure(16'hFFFF, 16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
		configure(16'd0, -16'sh8000, 1'b1);
		send_sample(-16'sd1, -16'sh8000, 16'sd0);
	endtask

	// Receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		configure(16'd3, 16'sd4096, 1'($urandom_range(0, 1)));
		hold_request = 400;
		allow_gaps   = 1'b0;
		repeat (48) send_random_sample();
		allow_gaps   = 1'b1;
	endtask

	task automatic test_random_phases();
		logic [DT_W-1:0] dt;
		logic [FB_W-1:0] fg;

		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 5))
				0:       dt = 16'd0;
				1:       dt = 16'hFFFF;
				2:       dt = 16'($urandom);
				default: dt = 16'($urandom_range(0, 40));
			endcase
			case ($urandom_range(0, 4))
				0:       fg = 16'sh7FFF;
				1:       fg = -16'sh8000;
				2:       fg = 16'($urandom);
				default: fg = 16'(int'($urandom_range(0, 8192)) - 4096);
			endcase
			configure(dt, fg, 1'($urandom_range(0, 1)));
			repeat (110) send_random_sample();
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (pending_echoes.size() == 0) begin
				report_mismatch($sformatf("unexpected result L=%0d R=%0d",
					dout_if.left_out, dout_if.right_out));
			end else begin
				oldest_echo = pending_echoes.pop_front();
				echoes_checked++;
				if (dout_if.left_out !== oldest_echo.left_out)
					report_mismatch($sformatf("left_out %0d, want %0d",
						dout_if.left_out, oldest_echo.left_out));
				if (dout_if.right_out !== oldest_echo.right_out)
					report_mismatch($sformatf("right_out %0d, want %0d",
						dout_if.right_out, oldest_echo.right_out));
			end
		end
	end

	// Receiver: random stall patterns, plus requested hold-offs
	initial begin
		int unsigned hold_left;
		int          pattern;
		int          pattern_left;

		hold_left     = 0;
		pattern       = 0;
		pattern_left  = 0;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				if (pattern_left <= 0) begin
					pattern      = $urandom_range(0, 3);
					pattern_left = $urandom_range(20, 120);
				end
				pattern_left--;
				case (pattern)
					0:       dout_if.ready <= 1'b1;
					1:       dout_if.ready <= ($urandom_range(0, 3) != 0);
					2:       dout_if.ready <= ($urandom_range(0, 3) == 0);
					default: dout_if.ready <= (pattern_left % 3 != 0);
				endcase
			end
		end
	end

	// Run limit
	initial begin
		#6000000;
		$display("Timed out with %0d results outstanding", pending_echoes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_DELAY_TIME;
		cfg_wdata          = '0;
		din_if.valid       = 1'b0;
		din_if.audio_in    = '0;
		din_if.delay_cv    = '0;
		din_if.feedback_cv = '0;
		head               = 0;
		primary_b          = 1'b0;
		model_delay        = DELAY_TIME_RST;
		model_gain         = FEEDBACK_GAIN_RST;
		model_bounce       = 1'b0;
		mismatch_count     = 0;
		samples_sent       = 0;
		echoes_checked     = 0;
		wrap_count         = 0;
		swap_count         = 0;
		sat_count          = 0;
		settings_count     = 1;
		burst_left         = 0;
		offering           = 1'b0;
		allow_gaps         = 1'b1;
		hold_request       = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_short_loop_saturation();
		test_bounce_swap();
		test_extreme_registers();
		test_backpressure();
		test_random_phases();
		drain_echoes();

		$display("Run covered %0d samples over %0d register settings, %0d results checked",
			samples_sent, settings_count, echoes_checked);
		$display("Head wraps %0d, store swaps %0d, saturated writes %0d",
			wrap_count, swap_count, sat_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
